### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interpolator assertion failed");

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interpolator assertion failed");

`endif

### sv/bpi_pkg.sv
// ----------------------------------------------------------------------------
// bpi_pkg
// Widths, types and constants shared by the bicubic interpolator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpi_pkg;

  localparam int PIX_W     = 8;
  localparam int FRAC_W    = 8;
  localparam int NUM_TAPS  = 4;
  localparam int COEF_W    = 12;
  localparam int WEIGHT_W  = 16;
  localparam int PROD_W    = COEF_W + WEIGHT_W + 1;
  localparam int SUM_W     = PROD_W + 1;
  localparam int SUM_SHIFT = 16;
  localparam int IN_W      = NUM_TAPS * PIX_W + 2 * FRAC_W;
  localparam int IN_BYTES  = (IN_W + 7) / 8;

  localparam logic [WEIGHT_W-1:0] D_SCALE = 16'd65532;
  localparam logic [PIX_W-1:0]    PIX_MAX = 8'd255;

  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic [FRAC_W-1:0]        frac_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [WEIGHT_W-1:0]      weight_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic                     start;
    frac_t                    frac;
    pix_t [NUM_TAPS-1:0]      pix;
  } cubic_req_t;

  typedef struct packed {
    logic valid;
    pix_t value;
  } cubic_rsp_t;

endpackage

`default_nettype wire

### sv/bpi_lane.sv
// ----------------------------------------------------------------------------
// bpi_lane
// One product lane: signed coefficient times unsigned weight, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpi_lane (
  input  logic            clk,
  input  logic            en,
  input  bpi_pkg::coef_t   coef,
  input  bpi_pkg::weight_t weight,
  output bpi_pkg::prod_t   prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= bpi_pkg::prod_t'(coef) * bpi_pkg::prod_t'($signed({1'b0, weight}));
    end
  end

endmodule

`default_nettype wire

### sv/bpi_merge.sv
// ----------------------------------------------------------------------------
// bpi_merge
// Sum the lane products, shift down and clamp to the pixel range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpi_merge (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   valid_in,
  input  bpi_pkg::prod_t [bpi_pkg::NUM_TAPS-1:0] prods,
  output bpi_pkg::cubic_rsp_t                    rsp
);

  bpi_pkg::sum_t sum_next;
  bpi_pkg::sum_t sum_q;
  logic          sum_valid;
  bpi_pkg::pix_t clamped;

  always_comb begin
    sum_next = '0;
    for (int i = 0; i < bpi_pkg::NUM_TAPS; i++) begin
      sum_next = sum_next + bpi_pkg::sum_t'(prods[i]);
    end
  end

  always_comb begin
    if (sum_q[bpi_pkg::SUM_W-1]) begin
      clamped = '0;
    end else if (|sum_q[bpi_pkg::SUM_W-2:bpi_pkg::SUM_SHIFT+bpi_pkg::PIX_W]) begin
      clamped = bpi_pkg::PIX_MAX;
    end else begin
      clamped = sum_q[bpi_pkg::SUM_SHIFT+bpi_pkg::PIX_W-1:bpi_pkg::SUM_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      sum_valid <= valid_in;
      rsp.valid <= sum_valid;
    end
    if (valid_in) begin
      sum_q <= sum_next;
    end
    if (sum_valid) begin
      rsp.value <= clamped;
    end
  end

endmodule

`default_nettype wire

### sv/bpi_cubic.sv
// ----------------------------------------------------------------------------
// bpi_cubic
// Catmull-Rom cubic over four taps: coefficients, powers of the fraction,
// four product lanes and a merging sum with clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpi_cubic (
  input  logic                clk,
  input  logic                rst,
  input  bpi_pkg::cubic_req_t req,
  output bpi_pkg::cubic_rsp_t rsp
);

  bpi_pkg::coef_t p_s [bpi_pkg::NUM_TAPS];
  bpi_pkg::coef_t raw_a;
  bpi_pkg::coef_t raw_b;
  bpi_pkg::coef_t raw_c;
  bpi_pkg::coef_t diff_12;

  bpi_pkg::coef_t  coef1 [bpi_pkg::NUM_TAPS];
  bpi_pkg::frac_t  t1;
  bpi_pkg::weight_t t2_1;
  logic            v1;

  bpi_pkg::coef_t   coef2 [bpi_pkg::NUM_TAPS];
  bpi_pkg::frac_t   t2r;
  bpi_pkg::weight_t t2_2;
  bpi_pkg::weight_t t3_2;
  logic             v2;
  logic             v3;

  logic [bpi_pkg::WEIGHT_W+bpi_pkg::FRAC_W-1:0] cube_full;
  bpi_pkg::weight_t weights [bpi_pkg::NUM_TAPS];
  bpi_pkg::prod_t [bpi_pkg::NUM_TAPS-1:0] prods;

  always_comb begin
    for (int i = 0; i < bpi_pkg::NUM_TAPS; i++) begin
      p_s[i] = bpi_pkg::coef_t'({4'b0000, req.pix[i]});
    end
    diff_12 = p_s[1] - p_s[2];
    raw_a   = (p_s[3] - p_s[0]) + diff_12 + diff_12 + diff_12;
    raw_b   = (p_s[0] <<< 1) - p_s[1] - (p_s[1] <<< 2) + (p_s[2] <<< 2) - p_s[3];
    raw_c   = p_s[2] - p_s[0];
  end

  assign cube_full = {8'h00, t2_1} * {16'h0000, t1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req.start;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      coef1[0] <= raw_a >>> 1;
      coef1[1] <= raw_b >>> 1;
      coef1[2] <= raw_c >>> 1;
      coef1[3] <= p_s[1];
      t1       <= req.frac;
      t2_1     <= bpi_pkg::weight_t'(req.frac) * bpi_pkg::weight_t'(req.frac);
    end
    if (v1) begin
      coef2 <= coef1;
      t2r   <= t1;
      t2_2  <= t2_1;
      t3_2  <= cube_full[bpi_pkg::WEIGHT_W+bpi_pkg::FRAC_W-1:bpi_pkg::FRAC_W];
    end
  end

  assign weights[0] = t3_2;
  assign weights[1] = t2_2;
  assign weights[2] = {t2r, 8'h00};
  assign weights[3] = bpi_pkg::D_SCALE;

  for (genvar g = 0; g < bpi_pkg::NUM_TAPS; g++) begin : g_lane
    bpi_lane u_lane (
      .clk    (clk),
      .en     (v2),
      .coef   (coef2[g]),
      .weight (weights[g]),
      .prod   (prods[g])
    );
  end

  bpi_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .valid_in (v3),
    .prods    (prods),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

### sv/bicubic_pixel_interpolator_core.sv
// ----------------------------------------------------------------------------
// bicubic_pixel_interpolator_core
// Bicubic (Catmull-Rom) pixel interpolator over a window of four pixel rows.
// ----------------------------------------------------------------------------
// Feed four row items per output pixel; each row is interpolated in x with
// frac_x, and the fourth row's frac_y drives the vertical pass over the four
// row results, giving one clamped pixel. One five-stage cubic unit (coefficient,
// cube, four product lanes, sum, clamp) serves both passes, one item at a
// time: the next row item is accepted only once the last one's result has
// left the unit, and the fourth row's result goes straight back in for the
// vertical pass. The next window's rows are taken while a finished pixel
// waits in m_tdata, but not while a second one waits in S_OUT.
`timescale 1ns / 1ps
`default_nettype none

module bicubic_pixel_interpolator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row_pixel_0, row_pixel_1, row_pixel_2, row_pixel_3, frac_x, frac_y
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_out
  output logic [7:0]  m_tdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ROW  = 4'b0010,
    S_COL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t              state;
  logic [1:0]          row_count;
  bpi_pkg::pix_t       row_results [3];
  bpi_pkg::frac_t      frac_y_q;
  bpi_pkg::pix_t       col_value;

  bpi_pkg::cubic_req_t req;
  bpi_pkg::cubic_rsp_t rsp;

  logic accept;
  logic col_launch;
  logic out_free;
  logic load_out;
  logic last_row;

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign last_row   = (row_count == 2'd3);
  assign col_launch = (state == S_ROW) && rsp.valid && last_row;
  assign out_free   = !m_tvalid || m_tready;
  assign load_out   = ((state == S_COL) && rsp.valid && out_free) ||
                      ((state == S_OUT) && out_free);

  always_comb begin
    req.start = accept || col_launch;
    if (col_launch) begin
      req.frac   = frac_y_q;
      req.pix[0] = row_results[0];
      req.pix[1] = row_results[1];
      req.pix[2] = row_results[2];
      req.pix[3] = rsp.value;
    end else begin
      req.frac   = s_tdata[39:32];
      req.pix[0] = s_tdata[7:0];
      req.pix[1] = s_tdata[15:8];
      req.pix[2] = s_tdata[23:16];
      req.pix[3] = s_tdata[31:24];
    end
  end

  bpi_cubic u_cubic (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row_count <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (rsp.valid) begin
            if (last_row) begin
              state <= S_COL;
            end else begin
              state     <= S_IDLE;
              row_count <= row_count + 2'd1;
            end
          end
        end
        S_COL: begin
          if (rsp.valid) begin
            row_count <= '0;
            state     <= out_free ? S_IDLE : S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      frac_y_q <= s_tdata[47:40];
    end
    if ((state == S_ROW) && rsp.valid && !last_row) begin
      row_results[row_count] <= rsp.value;
    end
    if ((state == S_COL) && rsp.valid) begin
      col_value <= rsp.value;
    end
    if (load_out) begin
      m_tdata <= (state == S_COL) ? rsp.value : col_value;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPLIES(a_no_rsp_idle, clk, rst, rsp.valid, state != S_IDLE)
  `ASSERT_IMPLIES(a_col_full_window, clk, rst, state == S_COL, row_count == 2'd3)
  `ASSERT_NEXT(a_one_item, clk, rst, accept, !s_tready)
  `ASSERT_IMPLIES(a_wait_full, clk, rst, state == S_OUT, m_tvalid)

endmodule

`default_nettype wire

### dv/tb_bicubic_pixel_interpolator_core.sv
// ----------------------------------------------------------------------------
// tb_bicubic_pixel_interpolator_core
// Self-checking bench for the bicubic pixel interpolator core.
// ----------------------------------------------------------------------------
// Streams four-row windows into the core and checks every output pixel
// against a local Catmull-Rom predictor (own row store) or a typed pixel.
// A directed table covers flat, saturated and overshooting windows, and
// shows that frac_y on the first three rows is ignored. A long random run
// follows. Both sides idle at random, with stretches of back-to-back
// traffic. The output side holds off once for a long stretch so that the
// core fills up and stalls its input.
`timescale 1ns / 1ps

module tb_bicubic_pixel_interpolator_core;

  localparam int DIR_ROWS  = 24;
  localparam int RAND_ROWS = 1328;
  localparam int HOLD_AT   = 60;
  localparam int HOLD_LEN  = 400;
  localparam int TAIL      = 40;
  localparam int LIMIT     = 3000;

  // fields from the lowest bit up: p0, p1, p2, p3, fx, fy
  typedef struct packed {
    bpi_pkg::pix_t  fy;
    bpi_pkg::frac_t fx;
    bpi_pkg::pix_t  p3;
    bpi_pkg::pix_t  p2;
    bpi_pkg::pix_t  p1;
    bpi_pkg::pix_t  p0;
  } row_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;

  bpi_pkg::pix_t row_store [3];
  logic [1:0] rows_held;
  bpi_pkg::pix_t pending_pixels [$];
  bpi_pkg::pix_t want_pix;
  int mismatches;
  int rows_sent;
  int pixels_seen;
  int quiet_cycles;
  bit tx_steady;
  bit rx_steady;

  // {fy, fx, p3, p2, p1, p0}
  logic [47:0] dir_row [DIR_ROWS] = '{
    48'h00_00_00_00_00_00, 48'h00_00_00_00_00_00,
    48'h00_00_00_00_00_00, 48'h00_00_00_00_00_00,
    48'hFF_00_FF_FF_FF_FF, 48'hFF_00_FF_FF_FF_FF,
    48'hFF_00_FF_FF_FF_FF, 48'h00_00_FF_FF_FF_FF,
    48'hFF_FF_FF_FF_FF_FF, 48'hFF_FF_FF_FF_FF_FF,
    48'hFF_FF_FF_FF_FF_FF, 48'hFF_FF_FF_FF_FF_FF,
    48'h00_80_00_FF_00_FF, 48'h00_80_00_FF_00_FF,
    48'h00_80_00_FF_00_FF, 48'h80_80_00_FF_00_FF,
    48'h00_FF_FF_00_FF_00, 48'h00_01_00_00_FF_FF,
    48'h00_FE_FF_FF_00_00, 48'h01_80_00_FF_FF_00,
    48'h00_40_63_2D_C8_0C, 48'h00_C0_0C_63_2D_C8,
    48'hAA_20_C8_0C_63_2D, 48'h40_E0_2D_C8_0C_63
  };
  // typed pixel for a window's fourth row, -1 where the predictor decides
  int dir_pixel [DIR_ROWS] = '{
    -1, -1, -1, 0,
    -1, -1, -1, 253,
    -1, -1, -1, -1,
    -1, -1, -1, -1,
    -1, -1, -1, -1,
    -1, -1, -1, -1
  };

  bicubic_pixel_interpolator_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bpi_pkg::pix_t cubic_point(input bpi_pkg::pix_t q0, q1, q2, q3,
                                                input bpi_pkg::frac_t f);
    longint s0, s1, s2, s3, t, a, b, c, acc, r;
    s0 = longint'(q0);
    s1 = longint'(q1);
    s2 = longint'(q2);
    s3 = longint'(q3);
    t = longint'(f);
    a = (-s0 + 3 * s1 - 3 * s2 + s3) >>> 1;
    b = (2 * s0 - 5 * s1 + 4 * s2 - s3) >>> 1;
    c = (s2 - s0) >>> 1;
    acc = a * ((t * t * t) / 256) + b * t * t + c * t * 256 +
          s1 * longint'(bpi_pkg::D_SCALE);
    r = acc >>> bpi_pkg::SUM_SHIFT;
    if (r < 0) r = 0;
    if (r > 255) r = 255;
    return bpi_pkg::pix_t'(r);
  endfunction

  // Interpolate one row; on the fourth row of a window run the vertical pass.
  function automatic bit take_row(input row_item_t r, output bpi_pkg::pix_t pixel);
    bpi_pkg::pix_t h;
    h = cubic_point(r.p0, r.p1, r.p2, r.p3, r.fx);
    pixel = '0;
    if (rows_held < 2'd3) begin
      row_store[rows_held] = h;
      rows_held = rows_held + 2'd1;
      return 1'b0;
    end
    pixel = cubic_point(row_store[0], row_store[1], row_store[2], h, r.fy);
    rows_held = 2'd0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic offer_row(input row_item_t r, input int known);
    int gap;
    bpi_pkg::pix_t pixel;
    gap = tx_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rows_sent++;
    if (take_row(r, pixel))
      pending_pixels.push_back(known >= 0 ? bpi_pkg::pix_t'(known) : pixel);
  endtask

  // check each output item against the oldest expected pixel
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        $error("pixel_out: unexpected item, expected none, actual %0d", m_tdata);
        mismatches++;
      end else begin
        want_pix = pending_pixels.pop_front();
        if (m_tdata !== want_pix) begin
          $error("pixel_out: expected %0d, actual %0d", want_pix, m_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // output side: random stalls, steady stretches and one long hold
  initial begin
    int gap;
    int taken;
    taken = 0;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 25 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = rx_steady ? 0 : $urandom_range(0, 13);
      if (taken == HOLD_AT) gap = HOLD_LEN;
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    row_item_t r;
    mismatches   = 0;
    rows_sent    = 0;
    pixels_seen  = 0;
    rows_held    = 2'd0;
    tx_steady    = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++)
      offer_row(row_item_t'(dir_row[i]), dir_pixel[i]);

    for (int i = 0; i < RAND_ROWS; i++) begin
      if (i % 100 == 0) tx_steady = ($urandom_range(0, 3) == 0);
      r.p0 = pick_byte();
      r.p1 = pick_byte();
      r.p2 = pick_byte();
      r.p3 = pick_byte();
      r.fx = pick_byte();
      r.fy = pick_byte();
      offer_row(r, -1);
    end
    s_tvalid <= 1'b0;

    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("pixel_out: %0d expected items never arrived", pending_pixels.size());
      mismatches++;
    end

    $display("Run covered %0d rows (%0d from the directed table), %0d pixels checked,",
             rows_sent, DIR_ROWS, pixels_seen);
    $display("with random idling on both sides and a %0d-cycle output hold.", HOLD_LEN);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
